FILE: hw/rtl/lppe_pkg.sv
// Shared types and constants of the lidar packet point extractor.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package lppe_pkg;

    localparam logic [7:0]  HDR_BYTE      = 8'h54;
    localparam logic [5:0]  START_LO_IDX  = 6'd4;
    localparam logic [5:0]  START_HI_IDX  = 6'd5;
    localparam logic [5:0]  TRIPLE_FIRST  = 6'd6;
    localparam logic [5:0]  TRIPLE_LAST   = 6'd41;
    localparam logic [5:0]  END_LO_IDX    = 6'd42;
    localparam logic [5:0]  END_HI_IDX    = 6'd43;
    localparam logic [5:0]  LAST_BYTE_IDX = 6'd46;

    localparam int          NPOINTS       = 12;
    localparam logic [16:0] FULL_TURN     = 17'd36000;
    localparam logic [4:0]  SPAN_DIV      = 5'd11;
    // ceil(2^24 / 11); exact quotient for every 16-bit span magnitude
    localparam logic [20:0] DIV_RECIP     = 21'd1525202;

    localparam logic [15:0] RST_OFFSET    = 16'd1500;
    localparam logic [15:0] RST_MIN_DIST  = 16'd50;
    localparam logic [15:0] RST_MAX_DIST  = 16'd12000;
    localparam logic [7:0]  RST_MIN_INT   = 8'd1;

    typedef enum logic [1:0] {
        CFG_OFFSET   = 2'd0,
        CFG_MIN_DIST = 2'd1,
        CFG_MAX_DIST = 2'd2,
        CFG_MIN_INT  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] offset;
        logic [15:0] min_dist;
        logic [15:0] max_dist;
        logic [7:0]  min_int;
    } t_cfg;

    typedef struct packed {
        logic        bank;
        logic [15:0] first_ang;
        logic [15:0] final_ang;
    } t_job;

    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [23:0] data;
    } t_pt_wr;

endpackage

FILE: hw/rtl/lppe_front.sv
// Front part: hunts for the header, counts packet bytes, assembles point triples
// into the point buffer and hands a finished packet to the job queue. Uses lppe_pkg.
`timescale 1ns / 1ps

module lppe_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_q_full,
    output logic                 o_push,
    output lppe_pkg::t_job       o_job,
    output lppe_pkg::t_pt_wr     o_wr
);
    import lppe_pkg::*;

    logic [5:0]  r_count;
    logic [1:0]  r_phase;
    logic [3:0]  r_pt;
    logic        r_bank;
    logic [15:0] r_start;
    logic [15:0] r_end;
    logic [7:0]  r_dlo;
    logic [7:0]  r_dhi;
    logic        w_acc;
    logic        w_in_triple;

    assign o_in_ready  = !i_q_full;
    assign w_acc       = i_in_valid && !i_q_full;
    assign w_in_triple = (r_count >= TRIPLE_FIRST) && (r_count <= TRIPLE_LAST);

    assign o_wr.en   = w_acc && w_in_triple && (r_phase == 2'd2);
    assign o_wr.addr = {r_bank, r_pt};
    assign o_wr.data = {i_rx_byte, r_dhi, r_dlo};

    assign o_push          = w_acc && (r_count == LAST_BYTE_IDX);
    assign o_job.bank      = r_bank;
    assign o_job.first_ang = r_start;
    assign o_job.final_ang = r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= '0;
            r_pt    <= '0;
            r_bank  <= 1'b0;
        end else if (w_acc) begin
            if (r_count == '0) begin
                if (i_rx_byte == HDR_BYTE) begin
                    r_count <= 6'd1;
                    r_phase <= '0;
                    r_pt    <= '0;
                end
            end else begin
                if (r_count == LAST_BYTE_IDX) begin
                    r_count <= '0;
                    r_bank  <= !r_bank;
                end else begin
                    r_count <= r_count + 6'd1;
                end
                if (w_in_triple) begin
                    if (r_phase == 2'd2) begin
                        r_phase <= '0;
                        r_pt    <= r_pt + 4'd1;
                    end else begin
                        r_phase <= r_phase + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            if (r_count == START_LO_IDX) r_start[7:0]  <= i_rx_byte;
            if (r_count == START_HI_IDX) r_start[15:8] <= i_rx_byte;
            if (r_count == END_LO_IDX)   r_end[7:0]    <= i_rx_byte;
            if (r_count == END_HI_IDX)   r_end[15:8]   <= i_rx_byte;
            if (w_in_triple && r_phase == 2'd0) r_dlo <= i_rx_byte;
            if (w_in_triple && r_phase == 2'd1) r_dhi <= i_rx_byte;
        end
    end

endmodule

FILE: hw/rtl/lppe_job_q.sv
// Two-entry queue of finished packets between the front and back parts.
// Each entry names its point buffer bank and the two packet angles. Uses lppe_pkg.
`timescale 1ns / 1ps

module lppe_job_q (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lppe_pkg::t_job       i_job,
    input  logic                 i_pop,
    output lppe_pkg::t_job       o_job,
    output logic                 o_empty,
    output logic                 o_full
);
    import lppe_pkg::*;

    t_job       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_job   = r_q[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_job;
    end

endmodule

FILE: hw/rtl/lppe_back.sv
// Back part: holds the two-bank point buffer, steps the interpolated angle point
// by point, filters each point and drives the output word register. Uses lppe_pkg.
`timescale 1ns / 1ps

module lppe_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lppe_pkg::t_cfg       i_cfg,
    input  lppe_pkg::t_pt_wr     i_wr,
    input  lppe_pkg::t_job       i_job,
    input  logic                 i_q_empty,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [15:0]          o_angle_cdeg,
    output logic [15:0]          o_distance_mm,
    output logic [7:0]           o_intensity,
    output logic                 o_last_point
);
    import lppe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SPAN, S_MUL, S_QR, S_RED, S_RD, S_EVAL, S_FLUSH
    } t_state;

    t_state       r_state;
    logic [23:0]  r_mem [32];
    logic [23:0]  r_rd_data;
    logic [15:0]  r_mag;
    logic         r_neg;
    logic [36:0]  r_prod;
    logic [12:0]  r_mq;
    logic [3:0]   r_mr;
    logic [3:0]   r_rem;
    logic [16:0]  r_ang;
    logic [3:0]   r_idx;
    logic         r_pend_valid;
    logic [15:0]  r_pend_ang;
    logic [15:0]  r_pend_dist;
    logic [7:0]   r_pend_int;
    logic         r_out_valid;
    logic [15:0]  r_out_ang;
    logic [15:0]  r_out_dist;
    logic [7:0]   r_out_int;
    logic         r_out_last;

    logic signed [17:0] w_diff;
    logic signed [17:0] w_span;
    logic signed [17:0] w_span_neg;
    logic [15:0]  w_mag;
    logic [12:0]  w_mq;
    logic [16:0]  w_mq11;
    logic [16:0]  w_mr_full;
    logic [16:0]  w_ang_red;
    logic [4:0]   w_rsum;
    logic         w_carry;
    logic [4:0]   w_rsub;
    logic [3:0]   w_rem_nx;
    logic [16:0]  w_delta;
    logic [16:0]  w_up;
    logic [16:0]  w_up_red;
    logic [17:0]  w_dn;
    logic [17:0]  w_dn_red;
    logic [16:0]  w_ang_nx;
    logic         w_rd_en;
    logic [15:0]  w_dist;
    logic [7:0]   w_int;
    logic         w_pass;
    logic         w_out_free;
    logic         w_out_load;

    assign w_diff     = $signed({2'b00, i_job.final_ang}) - $signed({2'b00, i_job.first_ang});
    assign w_span     = w_diff[17] ? w_diff + $signed({1'b0, FULL_TURN}) : w_diff;
    assign w_span_neg = -w_span;
    assign w_mag      = w_span[17] ? w_span_neg[15:0] : w_span[15:0];

    assign w_mq      = r_prod[36:24];
    assign w_mq11    = ({4'b0, w_mq} << 3) + ({4'b0, w_mq} << 1) + {4'b0, w_mq};
    assign w_mr_full = {1'b0, r_mag} - w_mq11;
    assign w_ang_red = (r_ang >= FULL_TURN) ? r_ang - FULL_TURN : r_ang;

    assign w_rsum   = {1'b0, r_rem} + {1'b0, r_mr};
    assign w_carry  = (w_rsum >= SPAN_DIV);
    assign w_rsub   = w_rsum - SPAN_DIV;
    assign w_rem_nx = w_carry ? w_rsub[3:0] : w_rsum[3:0];
    assign w_delta  = {4'b0, r_mq} + {16'b0, w_carry};
    assign w_up     = r_ang + w_delta;
    assign w_up_red = (w_up >= FULL_TURN) ? w_up - FULL_TURN : w_up;
    assign w_dn     = {1'b0, r_ang} - {1'b0, w_delta};
    assign w_dn_red = w_dn[17] ? w_dn + {1'b0, FULL_TURN} : w_dn;
    assign w_ang_nx = r_neg ? w_dn_red[16:0] : w_up_red;

    assign w_rd_en    = (r_state == S_RD);
    assign w_dist     = r_rd_data[15:0];
    assign w_int      = r_rd_data[23:16];
    assign w_pass     = (w_dist > i_cfg.min_dist) && (w_dist < i_cfg.max_dist) &&
                        (w_int >= i_cfg.min_int);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_out_load = w_out_free && r_pend_valid &&
                        (((r_state == S_EVAL) && w_pass) || (r_state == S_FLUSH));

    assign o_pop = (r_state == S_FLUSH) && (!r_pend_valid || w_out_free);

    assign o_out_valid   = r_out_valid;
    assign o_angle_cdeg  = r_out_ang;
    assign o_distance_mm = r_out_dist;
    assign o_intensity   = r_out_int;
    assign o_last_point  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) r_mem[i_wr.addr] <= i_wr.data;
        if (w_rd_en) r_rd_data <= r_mem[{i_job.bank, r_idx}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !w_out_load) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) r_state <= S_SPAN;
                end
                S_SPAN: begin
                    r_mag   <= w_mag;
                    r_neg   <= w_span[17];
                    r_ang   <= {1'b0, i_job.first_ang} + {1'b0, i_cfg.offset};
                    r_rem   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= r_mag * DIV_RECIP;
                    r_ang   <= w_ang_red;
                    r_state <= S_QR;
                end
                S_QR: begin
                    r_mq    <= w_mq;
                    r_mr    <= w_mr_full[3:0];
                    r_ang   <= w_ang_red;
                    r_state <= S_RED;
                end
                S_RED: begin
                    r_ang   <= w_ang_red;
                    r_idx   <= '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (!(w_pass && r_pend_valid && !w_out_free)) begin
                        if (w_pass) begin
                            if (r_pend_valid) begin
                                r_out_valid <= 1'b1;
                                r_out_ang   <= r_pend_ang;
                                r_out_dist  <= r_pend_dist;
                                r_out_int   <= r_pend_int;
                                r_out_last  <= 1'b0;
                            end
                            r_pend_valid <= 1'b1;
                            r_pend_ang   <= r_ang[15:0];
                            r_pend_dist  <= w_dist;
                            r_pend_int   <= w_int;
                        end
                        r_ang <= w_ang_nx;
                        r_rem <= w_rem_nx;
                        if (r_idx == 4'(NPOINTS - 1)) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_idx   <= r_idx + 4'd1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_valid) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_ang    <= r_pend_ang;
                        r_out_dist   <= r_pend_dist;
                        r_out_int    <= r_pend_int;
                        r_out_last   <= 1'b1;
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: hw/rtl/lidar_packet_point_extractor_top.sv
// Top level of the lidar packet point extractor: configuration registers,
// front part, job queue and back part. Uses lppe_pkg and all lppe_ modules.
`timescale 1ns / 1ps

// The block takes one byte word per cycle from the sensor link while input ready
// is high, drops bytes until the header 0x54 and gathers 47-byte packets; each
// packet yields up to twelve filtered point words, the last one flagged. Packet
// points go to one of two buffer banks, so a new packet is taken while the
// previous one is still being turned into points. The back part runs its setup
// once per packet and then, per point, one buffer read and one filter and angle
// step, which a stalled output can hold. Input ready falls only while both banks
// hold packets still awaiting their points. No clearing pass follows reset.
module lidar_packet_point_extractor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_angle_cdeg,
    output logic [15:0] o_distance_mm,
    output logic [7:0]  o_intensity,
    output logic        o_last_point
);
    import lppe_pkg::*;

    t_cfg   r_cfg;
    t_job   w_front_job;
    t_job   w_head_job;
    t_pt_wr w_wr;
    logic   w_push;
    logic   w_pop;
    logic   w_q_empty;
    logic   w_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset   <= RST_OFFSET;
            r_cfg.min_dist <= RST_MIN_DIST;
            r_cfg.max_dist <= RST_MAX_DIST;
            r_cfg.min_int  <= RST_MIN_INT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_OFFSET:   r_cfg.offset   <= i_cfg_data;
                CFG_MIN_DIST: r_cfg.min_dist <= i_cfg_data;
                CFG_MAX_DIST: r_cfg.max_dist <= i_cfg_data;
                CFG_MIN_INT:  r_cfg.min_int  <= i_cfg_data[7:0];
            endcase
        end
    end

    lppe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_job      (w_front_job),
        .o_wr       (w_wr)
    );

    lppe_job_q u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    lppe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_wr          (w_wr),
        .i_job         (w_head_job),
        .i_q_empty     (w_q_empty),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_angle_cdeg  (o_angle_cdeg),
        .o_distance_mm (o_distance_mm),
        .o_intensity   (o_intensity),
        .o_last_point  (o_last_point)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("packet pushed into a full job queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_empty)
        else $error("job popped from an empty queue");

    a_push_fills_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> !w_q_empty)
        else $error("job queue empty after a push");

    a_angle_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_angle_cdeg < FULL_TURN[15:0]))
        else $error("output angle not wrapped into one turn");
`endif

endmodule

FILE: verif/lidar_packet_point_extractor_top_tb.sv
// Self-checking testbench for lidar_packet_point_extractor_top: byte words in, point words out.
// A directed packet table is followed by random framed traffic with noise, each checked against
// known points or a local point predictor. Depends on lppe_pkg and the block's RTL.
`timescale 1ns / 1ps

module lidar_packet_point_extractor_top_tb;

    import lppe_pkg::*;

    typedef struct packed {
        logic [15:0] angle;
        logic [15:0] range_mm;
        logic [7:0]  inten;
        logic        last;
    } t_point;

    typedef struct {
        bit          wr_cfg;
        t_cfg        cfg;
        bit [15:0]   start_a;
        bit [15:0]   end_a;
        bit [15:0]   range_mm;
        bit [7:0]    inten;
        bit          rnd_triples;
        int          junk;
        int          known_n;
        bit [15:0]   known_angle;
    } t_packet_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_angle_cdeg;
    logic [15:0] o_distance_mm;
    logic [7:0]  o_intensity;
    logic        o_last_point;

    t_cfg         filt_cfg;
    int unsigned  gather_pos;
    logic [7:0]   gather_bytes [1:46];
    logic [7:0]   frame_bytes [0:46];
    t_point       expected_points [$];
    t_packet_row  dir_rows [$];
    bit           mute_prediction;
    bit           tx_idle_on;
    bit           rx_idle_on;
    int           rx_hold_left;
    int           mismatch_count;

    lidar_packet_point_extractor_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_angle_cdeg  (o_angle_cdeg),
        .o_distance_mm (o_distance_mm),
        .o_intensity   (o_intensity),
        .o_last_point  (o_last_point)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_cfg mk_cfg(input logic [15:0] offset, input logic [15:0] min_dist,
                                    input logic [15:0] max_dist, input logic [7:0] min_int);
        t_cfg c;
        c.offset   = offset;
        c.min_dist = min_dist;
        c.max_dist = max_dist;
        c.min_int  = min_int;
        return c;
    endfunction

    function automatic void extract_points();
        t_point      found [$];
        t_point      pt;
        int          start_a;
        int          end_a;
        int          span;
        int          ang;
        int          base;
        logic [15:0] range_mm;
        logic [7:0]  inten;
        start_a = int'({gather_bytes[START_HI_IDX], gather_bytes[START_LO_IDX]});
        end_a   = int'({gather_bytes[END_HI_IDX], gather_bytes[END_LO_IDX]});
        span    = end_a - start_a;
        if (span < 0) begin
            span += int'(FULL_TURN);
        end
        for (int i = 0; i < NPOINTS; i++) begin
            base     = int'(TRIPLE_FIRST) + 3 * i;
            range_mm = {gather_bytes[base + 1], gather_bytes[base]};
            inten    = gather_bytes[base + 2];
            // The interpolated step truncates towards zero, even for a negative span.
            ang = start_a + (i * span) / int'(SPAN_DIV) + int'(filt_cfg.offset);
            ang = ang % int'(FULL_TURN);
            if (ang < 0) begin
                ang += int'(FULL_TURN);
            end
            if (range_mm > filt_cfg.min_dist && range_mm < filt_cfg.max_dist &&
                inten >= filt_cfg.min_int) begin
                pt.angle    = ang[15:0];
                pt.range_mm = range_mm;
                pt.inten    = inten;
                pt.last     = 1'b0;
                found = {found, pt};
            end
        end
        if (found.size() > 0) begin
            found[found.size() - 1].last = 1'b1;
        end
        if (!mute_prediction) begin
            foreach (found[k]) expected_points = {expected_points, found[k]};
        end
    endfunction

    function automatic void predict_rx_byte(input logic [7:0] b);
        if (gather_pos == 0) begin
            if (b == HDR_BYTE) begin
                gather_pos = 1;
            end
        end else begin
            gather_bytes[gather_pos] = b;
            gather_pos++;
            if (gather_pos > LAST_BYTE_IDX) begin
                gather_pos = 0;
                extract_points();
            end
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function automatic void check_point(input t_point got);
        t_point want;
        if (expected_points.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected point, expected none, actual angle %0d dist %0d int %0d last %0b",
                     $time, got.angle, got.range_mm, got.inten, got.last);
            return;
        end
        want = expected_points.pop_front();
        check_field("angle_cdeg", want.angle, got.angle);
        check_field("distance_mm", want.range_mm, got.range_mm);
        check_field("intensity", want.inten, got.inten);
        check_field("last_point", want.last, got.last);
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom);
        while (b == HDR_BYTE) b = 8'($urandom);
        return b;
    endfunction

    function automatic void frame_head(input logic [15:0] start_a, input logic [15:0] end_a);
        frame_bytes[0] = HDR_BYTE;
        for (int k = 1; k <= 46; k++) frame_bytes[k] = 8'($urandom);
        frame_bytes[START_LO_IDX] = start_a[7:0];
        frame_bytes[START_HI_IDX] = start_a[15:8];
        frame_bytes[END_LO_IDX]   = end_a[7:0];
        frame_bytes[END_HI_IDX]   = end_a[15:8];
    endfunction

    function automatic void frame_triple(input int i, input logic [15:0] range_mm,
                                         input logic [7:0] inten);
        frame_bytes[int'(TRIPLE_FIRST) + 3 * i]     = range_mm[7:0];
        frame_bytes[int'(TRIPLE_FIRST) + 3 * i + 1] = range_mm[15:8];
        frame_bytes[int'(TRIPLE_FIRST) + 3 * i + 2] = inten;
    endfunction

    function automatic void frame_random_triples();
        logic [15:0] range_mm;
        for (int i = 0; i < NPOINTS; i++) begin
            range_mm = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 14000));
            frame_triple(i, range_mm, 8'($urandom));
        end
    endfunction

    function automatic void add_row(input bit wr_cfg, input t_cfg cfg, input bit [15:0] start_a,
                                    input bit [15:0] end_a, input bit [15:0] range_mm,
                                    input bit [7:0] inten, input bit rnd_triples, input int junk,
                                    input int known_n, input bit [15:0] known_angle);
        t_packet_row row;
        row.wr_cfg      = wr_cfg;
        row.cfg         = cfg;
        row.start_a     = start_a;
        row.end_a       = end_a;
        row.range_mm    = range_mm;
        row.inten       = inten;
        row.rnd_triples = rnd_triples;
        row.junk        = junk;
        row.known_n     = known_n;
        row.known_angle = known_angle;
        dir_rows = {dir_rows, row};
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_rx_byte(b);
    endtask

    task automatic send_frame();
        for (int k = 0; k <= 46; k++) send_byte(frame_bytes[k]);
    endtask

    // Completes any packet left open by a truncated sequence, so that framing is clean.
    task automatic close_packet();
        while (gather_pos != 0) send_byte(8'($urandom));
    endtask

    // A packet that yields no point may still be in the back part, hence the pause.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic load_filter(input t_cfg c);
        t_cfg_idx    idx;
        logic [15:0] val;
        for (int r = 0; r < 4; r++) begin
            idx = t_cfg_idx'(r);
            case (idx)
                CFG_OFFSET:   val = c.offset;
                CFG_MIN_DIST: val = c.min_dist;
                CFG_MAX_DIST: val = c.max_dist;
                default:      val = {8'($urandom), c.min_int};
            endcase
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= val;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        filt_cfg = c;
    endtask

    initial begin
        int     hold_wait;
        t_point got;
        hold_wait = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready) begin
                got = {o_angle_cdeg, o_distance_mm, o_intensity, o_last_point};
                check_point(got);
                hold_wait = rx_idle_on ? $urandom_range(0, 4) : 0;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_wait > 0) begin
                hold_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        t_packet_row row;
        t_point      pt;
        t_cfg        rc;
        t_cfg        c;
        int          s;
        int          e;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_OFFSET;
        i_cfg_data      <= 16'd0;
        i_in_valid      <= 1'b0;
        i_rx_byte       <= 8'd0;
        mismatch_count  = 0;
        gather_pos      = 0;
        mute_prediction = 1'b0;
        tx_idle_on      = 1'b1;
        rx_idle_on      = 1'b1;
        rx_hold_left    = 0;
        rc = mk_cfg(RST_OFFSET, RST_MIN_DIST, RST_MAX_DIST, RST_MIN_INT);
        filt_cfg = rc;

        add_row(1'b0, rc, 16'd0, 16'd0, 16'd1000, 8'd100, 1'b0, 3, 12, 16'd1500);
        add_row(1'b0, rc, 16'd100, 16'd100, 16'd12000, 8'd100, 1'b0, 1, 0, 16'd0);
        add_row(1'b1, mk_cfg(16'd65535, 16'd0, 16'd65535, 8'd255), 16'd65535, 16'd65535,
                16'd40000, 8'd255, 1'b0, 0, 12, 16'd23070);
        add_row(1'b1, mk_cfg(16'd0, 16'd0, 16'd65535, 8'd0), 16'd65535, 16'd0, 16'd500, 8'd7,
                1'b0, 0, -1, 16'd0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            if (row.wr_cfg) begin
                wait_drain();
                load_filter(row.cfg);
            end
            repeat (row.junk) send_byte(noise_byte());
            frame_head(row.start_a, row.end_a);
            if (row.rnd_triples) begin
                frame_random_triples();
            end else begin
                for (int i = 0; i < NPOINTS; i++) frame_triple(i, row.range_mm, row.inten);
            end
            if (row.known_n >= 0) begin
                for (int k = 0; k < row.known_n; k++) begin
                    pt.angle    = row.known_angle;
                    pt.range_mm = row.range_mm;
                    pt.inten    = row.inten;
                    pt.last     = (k == row.known_n - 1);
                    expected_points = {expected_points, pt};
                end
                mute_prediction = 1'b1;
            end
            send_frame();
            mute_prediction = 1'b0;
        end

        wait_drain();
        c = mk_cfg(16'($urandom_range(0, 35999)), 16'($urandom_range(0, 1500)),
                   16'($urandom_range(2000, 65535)), 8'($urandom_range(0, 40)));
        load_filter(c);
        // Hold the output back so that both banks fill and the input stalls.
        rx_hold_left = 600;
        for (int p = 0; p < 4; p++) begin
            repeat ($urandom_range(0, 3)) send_byte(noise_byte());
            if ($urandom_range(0, 5) == 0) begin
                send_byte(HDR_BYTE);
                repeat ($urandom_range(1, 45)) send_byte(8'($urandom));
            end
            s = ($urandom_range(0, 7) == 0) ? int'(16'($urandom)) : $urandom_range(0, 35999);
            e = ($urandom_range(0, 7) == 0) ? int'(16'($urandom))
                                            : (s + $urandom_range(0, 1500)) % 36000;
            frame_head(s[15:0], e[15:0]);
            frame_random_triples();
            send_frame();
        end
        close_packet();

        wait_drain();
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #(500_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/lppe_pkg.sv
hw/rtl/lppe_front.sv
hw/rtl/lppe_job_q.sv
hw/rtl/lppe_back.sv
hw/rtl/lidar_packet_point_extractor_top.sv
verif/lidar_packet_point_extractor_top_tb.sv
